// ----- rtl/tpp_pkg.sv -----
`default_nettype none
package tpp_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PERIOD_BITS = 16;
   localparam int MINMOVE_BITS = 16;
   // wide enough for accel * t * t and for the shifted total-time numerator
   localparam int ALU_BITS   = 3 * WORD_BITS + 2;
   localparam int SPEED_MIN  = ((1 << FRAC_BITS) + 9999) / 10000;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEL_LIMIT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_MOVE      = 2'd2;

   localparam logic [WORD_BITS-2:0]    ACCEL_LIMIT_RESET = (WORD_BITS-1)'(655360);
   localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET      = PERIOD_BITS'(655);
   localparam logic [MINMOVE_BITS-1:0] MIN_MOVE_RESET    = MINMOVE_BITS'(66);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic                        start_req;
      logic signed [WORD_BITS-1:0] start_position;
      logic signed [WORD_BITS-1:0] target_position;
      logic [WORD_BITS-2:0]        cruise_speed;
      logic [WORD_BITS-2:0]        acceleration;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] position;
      logic                        moving;
      logic                        rejected;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } alu_cmd_type;

   typedef struct packed {
      logic done;
      logic carry;
   } alu_sts_type;

endpackage
`default_nettype wire

// ----- rtl/tpp_alu.sv -----
`default_nettype none
module tpp_alu (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  tpp_pkg::alu_cmd_type     cmd,
   input  wire  [tpp_pkg::ALU_BITS-1:0]   a,
   input  wire  [tpp_pkg::ALU_BITS-1:0]   b,
   output logic [tpp_pkg::ALU_BITS-1:0]   res,
   output tpp_pkg::alu_sts_type           sts
);
   import tpp_pkg::*;

   localparam int X = ALU_BITS;
   localparam int N = WORD_BITS;
   localparam int CW = $clog2(X + 1);

   logic          busy_ff, busy_in;
   logic [1:0]    op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [X-1:0]  acc_ff, acc_in;
   logic [X-1:0]  sh_ff, sh_in;
   logic [X-1:0]  mp_ff, mp_in;
   logic [X-1:0]  res_ff, res_in;
   logic          done_ff, done_in;
   logic          carry_ff, carry_in;

   logic [X:0]    x_op, y_op, rs;
   logic          sub;
   logic [X+1:0]  sum;
   logic          is_mul;

   assign is_mul = (op_ff == OP_MUL);
   assign rs = {acc_ff, sh_ff[X-1]};

   // the one shared adder
   always_comb begin
      if (busy_ff) begin
         if (is_mul) begin
            x_op = {1'b0, acc_ff};
            y_op = mp_ff[0] ? {1'b0, sh_ff} : '0;
            sub  = 1'b0;
         end else begin
            x_op = rs;
            y_op = {1'b0, mp_ff};
            sub  = 1'b1;
         end
      end else begin
         x_op = {1'b0, a};
         y_op = {1'b0, b};
         sub  = (cmd.op == OP_SUB);
      end
      sum = {1'b0, x_op} + {1'b0, sub ? ~y_op : y_op} + {{(X+1){1'b0}}, sub};
   end

   always_comb begin
      busy_in  = busy_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      mp_in    = mp_ff;
      res_in   = res_ff;
      carry_in = carry_ff;
      done_in  = 1'b0;
      if (busy_ff) begin
         if (is_mul) begin
            acc_in = sum[X-1:0];
            sh_in  = sh_ff << 1;
            mp_in  = mp_ff >> 1;
         end else begin
            // restoring step: keep the difference when it did not borrow
            acc_in = sum[X+1] ? sum[X-1:0] : rs[X-1:0];
            sh_in  = {sh_ff[X-2:0], sum[X+1]};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = is_mul ? acc_in : sh_in;
         end
      end else if (cmd.start) begin
         op_in = cmd.op;
         unique case (cmd.op)
            OP_ADD, OP_SUB: begin
               res_in   = sum[X-1:0];
               carry_in = sum[X+1];
               done_in  = 1'b1;
            end
            OP_MUL: begin
               busy_in = 1'b1;
               cnt_in  = CW'(N);
               acc_in  = '0;
               sh_in   = a;
               mp_in   = b;
            end
            default: begin
               if (b == '0) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  cnt_in  = CW'(X);
                  acc_in  = '0;
                  sh_in   = a;
                  mp_in   = b;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      sh_ff    <= sh_in;
      mp_ff    <= mp_in;
      res_ff   <= res_in;
      carry_ff <= carry_in;
   end

   assign res       = res_ff;
   assign sts.done  = done_ff;
   assign sts.carry = carry_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("alu start while busy");
   a_done_cause: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff || cmd.start)) else $error("alu done without work");
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && cmd.start && cmd.op == OP_DIV && b == '0) |=> (done_ff && res_ff == '0))
      else $error("divide by zero not zero");
`endif
endmodule
`default_nettype wire

// ----- rtl/trapezoid_position_profile.sv -----
`default_nettype none
// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_stall  | req_data (start, positions, speed, accel)
// rsp      | out       | rsp_valid/rsp_stall  | rsp_data (position, moving, rejected)
// csr      | in        | csr_valid/csr_ready  | csr_index, csr_data
// a start adds 4 multiplies, 2 divides (3 with the triangle case) and 2 add/subtract steps;
// a running tick takes 1 to 3 multiplies, up to one divide, up to one add and one subtract,
// all on tpp_alu
// req_stall is high from the accepted word until its result is loaded
// reset is synchronous and gives the stopped state with the default registers
module trapezoid_position_profile (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  tpp_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output tpp_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [tpp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [tpp_pkg::WORD_BITS-1:0]         csr_data
);
   import tpp_pkg::*;

   localparam int N = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int X = ALU_BITS;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_VV   = 5'd1;
   localparam logic [4:0] ST_LA   = 5'd2;
   localparam logic [4:0] ST_CMP  = 5'd3;
   localparam logic [4:0] ST_TRI  = 5'd4;
   localparam logic [4:0] ST_TS   = 5'd5;
   localparam logic [4:0] ST_AL   = 5'd6;
   localparam logic [4:0] ST_ADD  = 5'd7;
   localparam logic [4:0] ST_AV   = 5'd8;
   localparam logic [4:0] ST_T    = 5'd9;
   localparam logic [4:0] ST_TICK = 5'd10;
   localparam logic [4:0] ST_A1   = 5'd11;
   localparam logic [4:0] ST_A2   = 5'd12;
   localparam logic [4:0] ST_C1   = 5'd13;
   localparam logic [4:0] ST_C2   = 5'd14;
   localparam logic [4:0] ST_D1   = 5'd15;
   localparam logic [4:0] ST_D2   = 5'd16;
   localparam logic [4:0] ST_D3   = 5'd17;
   localparam logic [4:0] ST_D4   = 5'd18;
   localparam logic [4:0] ST_D5   = 5'd19;
   localparam logic [4:0] ST_DIFF = 5'd20;
   localparam logic [4:0] ST_OUT  = 5'd21;

   function automatic logic [N-1:0] sat_word(input logic [X-1:0] x);
      sat_word = (|x[X-1:N]) ? {N{1'b1}} : x[N-1:0];
   endfunction

   function automatic logic [X-1:0] widen(input logic [N-1:0] x);
      widen = {{(X-N){1'b0}}, x};
   endfunction

   logic [N-2:0]          accel_limit_ff;
   logic [PERIOD_BITS-1:0]  period_ff;
   logic [MINMOVE_BITS-1:0] min_move_ff;

   logic [4:0]   state_ff, state_in;
   logic         issued_ff, issued_in;
   logic         phase_ff, phase_in;
   logic [N-1:0] origin_ff, origin_in, goal_ff, goal_in;
   logic [N-1:0] speed_ff, speed_in, accel_ff, accel_in, len_ff, len_in;
   logic [N-1:0] ramp_ff, ramp_in, total_ff, total_in, elapsed_ff, elapsed_in;
   logic [N-1:0] t_ff, t_in, back_ff, back_in, pos_ff, pos_in;
   logic [X-1:0] vv_ff, vv_in, tmp_ff, tmp_in, tmp2_ff, tmp2_in, p_ff, p_in, n_ff, n_in;
   logic         rej_ff, rej_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   alu_cmd_type  alu_cmd;
   alu_sts_type  alu_sts;
   logic [X-1:0] alu_a, alu_b, alu_res;

   logic [N-1:0] s_w, g_w, v_w, a_w, a_cl, len_w, tri_a, tc;
   logic [N:0]   diff_w, neg_w, el_sum;
   logic         rej_w, short_w, accept, out_free, is_op, gt, up;
   logic [N-1:0] w_dist;

   tpp_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .a     (alu_a),
      .b     (alu_b),
      .res   (alu_res),
      .sts   (alu_sts)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_limit_ff <= ACCEL_LIMIT_RESET;
         period_ff      <= PERIOD_RESET;
         min_move_ff    <= MIN_MOVE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCEL_LIMIT:   accel_limit_ff <= csr_data[N-2:0];
            CSR_SAMPLE_PERIOD: period_ff      <= csr_data[PERIOD_BITS-1:0];
            CSR_MIN_MOVE:      min_move_ff    <= csr_data[MINMOVE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // start word decode
   always_comb begin
      s_w     = req_data.start_position;
      g_w     = req_data.target_position;
      v_w     = {1'b0, req_data.cruise_speed};
      a_w     = {1'b0, req_data.acceleration};
      rej_w   = (v_w < N'(SPEED_MIN)) || (a_w < N'(SPEED_MIN));
      diff_w  = {g_w[N-1], g_w} - {s_w[N-1], s_w};
      neg_w   = ~diff_w + 1'b1;
      len_w   = diff_w[N] ? neg_w[N-1:0] : diff_w[N-1:0];
      a_cl    = (a_w > {1'b0, accel_limit_ff}) ? {1'b0, accel_limit_ff} : a_w;
      short_w = (len_w <= {{(N-MINMOVE_BITS){1'b0}}, min_move_ff});
   end

   assign is_op = (state_ff != ST_IDLE) && (state_ff != ST_TICK) && (state_ff != ST_OUT);

   // operand select for the shared unit
   always_comb begin
      alu_cmd.op = OP_MUL;
      alu_a      = '0;
      alu_b      = '0;
      unique case (state_ff)
         ST_VV:   begin alu_a = widen(speed_ff); alu_b = widen(speed_ff); end
         ST_LA:   begin alu_a = widen(len_ff);   alu_b = widen(accel_ff); end
         ST_CMP:  begin alu_cmd.op = OP_SUB; alu_a = vv_ff; alu_b = tmp_ff; end
         ST_TRI:  begin alu_cmd.op = OP_DIV; alu_a = vv_ff; alu_b = widen(len_ff); end
         ST_TS:   begin
            alu_cmd.op = OP_DIV;
            alu_a = widen(speed_ff) << F;
            alu_b = widen(accel_ff);
         end
         ST_AL:   begin alu_a = widen(len_ff);   alu_b = widen(accel_ff); end
         ST_ADD:  begin alu_cmd.op = OP_ADD; alu_a = vv_ff; alu_b = tmp_ff; end
         ST_AV:   begin alu_a = widen(speed_ff); alu_b = widen(accel_ff); end
         ST_T:    begin alu_cmd.op = OP_DIV; alu_a = tmp_ff << F; alu_b = tmp2_ff; end
         ST_A1:   begin alu_a = widen(t_ff);     alu_b = widen(t_ff); end
         ST_A2:   begin alu_a = tmp_ff;          alu_b = widen(accel_ff); end
         ST_C1:   begin alu_a = widen(speed_ff); alu_b = widen(t_ff); end
         ST_C2:   begin
            alu_cmd.op = OP_DIV;
            alu_a = vv_ff;
            alu_b = widen(accel_ff) << 1;
         end
         ST_D1:   begin alu_a = widen(back_ff);  alu_b = widen(back_ff); end
         ST_D2:   begin alu_a = tmp_ff;          alu_b = widen(accel_ff); end
         ST_D3:   begin alu_cmd.op = OP_DIV; alu_a = vv_ff; alu_b = widen(accel_ff); end
         ST_D4:   begin alu_cmd.op = OP_ADD; alu_a = tmp_ff; alu_b = tmp2_ff; end
         ST_D5:   begin alu_a = widen(speed_ff); alu_b = widen(total_ff); end
         ST_DIFF: begin alu_cmd.op = OP_SUB; alu_a = p_ff; alu_b = n_ff; end
         default: ;
      endcase
      alu_cmd.start = is_op && !issued_ff;
   end

   // distance guard and position for the last step of a running tick, triangle accel, clamped time
   always_comb begin
      gt     = alu_sts.carry && (alu_res != '0);
      w_dist = !gt ? '0 :
               ((|alu_res[X-1:N]) || (alu_res[N-1:0] > len_ff)) ? len_ff : alu_res[N-1:0];
      up     = ($signed(goal_ff) >= $signed(origin_ff));
      el_sum = {1'b0, elapsed_ff} + {{(N+1-PERIOD_BITS){1'b0}}, period_ff};
      tri_a  = sat_word(alu_res);
      tc     = (elapsed_ff > total_ff) ? total_ff : elapsed_ff;
   end

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      phase_in     = phase_ff;
      origin_in    = origin_ff;
      goal_in      = goal_ff;
      speed_in     = speed_ff;
      accel_in     = accel_ff;
      len_in       = len_ff;
      ramp_in      = ramp_ff;
      total_in     = total_ff;
      elapsed_in   = elapsed_ff;
      t_in         = t_ff;
      back_in      = back_ff;
      pos_in       = pos_ff;
      vv_in        = vv_ff;
      tmp_in       = tmp_ff;
      tmp2_in      = tmp2_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      rej_in       = rej_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (alu_cmd.start) issued_in = 1'b1;
      if (alu_sts.done)  issued_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rej_in   = 1'b0;
               state_in = ST_TICK;
               if (req_data.start_req) begin
                  elapsed_in = '0;
                  ramp_in    = '0;
                  total_in   = '0;
                  speed_in   = v_w;
                  accel_in   = a_w;
                  phase_in   = 1'b0;
                  origin_in  = s_w;
                  if (rej_w) begin
                     goal_in = s_w;
                     len_in  = '0;
                     rej_in  = 1'b1;
                  end else begin
                     goal_in  = g_w;
                     len_in   = len_w;
                     accel_in = a_cl;
                     if (!short_w) state_in = ST_VV;
                  end
               end
            end
         end
         ST_VV:  if (alu_sts.done) begin vv_in = alu_res;  state_in = ST_LA; end
         ST_LA:  if (alu_sts.done) begin tmp_in = alu_res; state_in = ST_CMP; end
         ST_CMP: if (alu_sts.done) state_in = alu_sts.carry ? ST_TRI : ST_TS;
         ST_TRI: if (alu_sts.done) begin
            // triangle: accel from speed squared over length
            accel_in = (tri_a == '0) ? N'(1) : tri_a;
            state_in = ST_TS;
         end
         ST_TS:  if (alu_sts.done) begin ramp_in = sat_word(alu_res); state_in = ST_AL; end
         ST_AL:  if (alu_sts.done) begin tmp_in = alu_res;  state_in = ST_ADD; end
         ST_ADD: if (alu_sts.done) begin tmp_in = alu_res;  state_in = ST_AV; end
         ST_AV:  if (alu_sts.done) begin tmp2_in = alu_res; state_in = ST_T; end
         ST_T:   if (alu_sts.done) begin
            total_in = sat_word(alu_res);
            phase_in = 1'b1;
            state_in = ST_TICK;
         end
         ST_TICK: begin
            t_in = elapsed_ff;
            if (!phase_ff) begin
               elapsed_in = '0;
               total_in   = '0;
               pos_in     = goal_ff;
               state_in   = ST_OUT;
            end else if (elapsed_ff <= ramp_ff) begin
               state_in = ST_A1;
            end else if (total_ff >= ramp_ff && elapsed_ff <= total_ff - ramp_ff) begin
               state_in = ST_C1;
            end else begin
               if (elapsed_ff > total_ff) phase_in = 1'b0;
               back_in  = total_ff - tc;
               state_in = ST_D1;
            end
         end
         ST_A1: if (alu_sts.done) begin tmp_in = alu_res; state_in = ST_A2; end
         ST_A2: if (alu_sts.done) begin
            p_in     = alu_res >> (2 * F + 1);
            n_in     = '0;
            state_in = ST_DIFF;
         end
         ST_C1: if (alu_sts.done) begin p_in = alu_res >> F; state_in = ST_C2; end
         ST_C2: if (alu_sts.done) begin n_in = alu_res; state_in = ST_DIFF; end
         ST_D1: if (alu_sts.done) begin tmp_in = alu_res; state_in = ST_D2; end
         ST_D2: if (alu_sts.done) begin tmp_in = alu_res >> (2 * F + 1); state_in = ST_D3; end
         ST_D3: if (alu_sts.done) begin tmp2_in = alu_res; state_in = ST_D4; end
         ST_D4: if (alu_sts.done) begin n_in = alu_res; state_in = ST_D5; end
         ST_D5: if (alu_sts.done) begin p_in = alu_res >> F; state_in = ST_DIFF; end
         ST_DIFF: if (alu_sts.done) begin
            pos_in     = up ? origin_ff + w_dist : origin_ff - w_dist;
            elapsed_in = el_sum[N] ? {N{1'b1}} : el_sum[N-1:0];
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_in.position = pos_ff;
               rsp_data_in.moving   = phase_ff;
               rsp_data_in.rejected = rej_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         origin_ff    <= '0;
         goal_ff      <= '0;
         speed_ff     <= '0;
         accel_ff     <= '0;
         len_ff       <= '0;
         ramp_ff      <= '0;
         total_ff     <= '0;
         elapsed_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         origin_ff    <= origin_in;
         goal_ff      <= goal_in;
         speed_ff     <= speed_in;
         accel_ff     <= accel_in;
         len_ff       <= len_in;
         ramp_ff      <= ramp_in;
         total_ff     <= total_in;
         elapsed_ff   <= elapsed_in;
      end
      t_ff        <= t_in;
      back_ff     <= back_in;
      pos_ff      <= pos_in;
      vv_ff       <= vv_in;
      tmp_ff      <= tmp_in;
      tmp2_ff     <= tmp2_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      rej_ff      <= rej_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE) else $error("word accepted but block idle");
   a_rej_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.rejected) |-> !rsp_data_ff.moving)
      else $error("rejected move reports moving");
   a_accel_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> accel_ff != '0) else $error("running with zero acceleration");
`endif
endmodule
`default_nettype wire

// ----- tb/trapezoid_position_profile_checker.sv -----
`default_nettype none
module trapezoid_position_profile_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  wire  tpp_pkg::req_type             req_data,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  wire  tpp_pkg::rsp_type             rsp_data,
   input  wire                                csr_valid,
   input  wire                                csr_ready,
   input  wire  [tpp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [tpp_pkg::WORD_BITS-1:0]      csr_data,
   output int                                 mismatches,
   output int                                 pending
);
   import tpp_pkg::*;

   localparam int WB = 192;
   localparam logic [WB-1:0] WORD_MAX = {{(WB-WORD_BITS){1'b0}}, {WORD_BITS{1'b1}}};

   // configuration copy
   logic [WORD_BITS-2:0]    cfg_accel_limit;
   logic [PERIOD_BITS-1:0]  cfg_period;
   logic [MINMOVE_BITS-1:0] cfg_min_move;

   // motion state copy
   logic                        running;
   logic signed [WORD_BITS-1:0] origin, goal;
   logic [WORD_BITS-1:0]        speed, accel, length, ramp_t, total_t, elapsed_t;

   rsp_type expected_positions[$];

   function automatic logic [WB-1:0] clamp_to(logic [WB-1:0] x, logic [WB-1:0] lim);
      return (x > lim) ? lim : x;
   endfunction

   task automatic step_profile(input req_type in_word, output rsp_type out_word);
      logic signed [63:0] s64, g64, diff, pos64;
      logic [WB-1:0]      v, a, len, vv, p, n, t, back, w;
      logic               rej;
      rej = 1'b0;
      if (in_word.start_req) begin
         s64 = 64'(in_word.start_position);
         g64 = 64'(in_word.target_position);
         v = WB'(in_word.cruise_speed);
         a = WB'(in_word.acceleration);
         elapsed_t = '0;
         ramp_t = '0;
         total_t = '0;
         speed = v[WORD_BITS-1:0];
         accel = a[WORD_BITS-1:0];
         running = 1'b0;
         if (v < SPEED_MIN || a < SPEED_MIN) begin
            origin = in_word.start_position;
            goal = in_word.start_position;
            length = '0;
            rej = 1'b1;
         end else begin
            diff = g64 - s64;
            len = (diff < 0) ? WB'(-diff) : WB'(diff);
            origin = in_word.start_position;
            goal = in_word.target_position;
            length = len[WORD_BITS-1:0];
            if (a > WB'(cfg_accel_limit)) a = WB'(cfg_accel_limit);
            if (len > WB'(cfg_min_move)) begin
               vv = v * v;
               // triangle profile: no room to cruise
               if (len * a <= vv) begin
                  a = clamp_to(vv / len, WORD_MAX);
                  if (a == 0) a = 1;
               end
               ramp_t = WORD_BITS'(clamp_to((v << FRAC_BITS) / a, WORD_MAX));
               total_t = WORD_BITS'(clamp_to(((vv + a * len) << FRAC_BITS) / (a * v),
                                             WORD_MAX));
               running = 1'b1;
            end
            accel = a[WORD_BITS-1:0];
         end
      end
      if (running) begin
         a = WB'(accel);
         v = WB'(speed);
         vv = v * v;
         t = WB'(elapsed_t);
         if (t <= ramp_t) begin
            p = (a * t * t) >> (2 * FRAC_BITS + 1);
            n = '0;
         end else if (total_t >= ramp_t && t <= total_t - ramp_t) begin
            p = (v * t) >> FRAC_BITS;
            n = vv / (a << 1);
         end else begin
            if (t > total_t) begin
               t = WB'(total_t);
               running = 1'b0;
            end
            back = WB'(total_t) - t;
            p = (v * WB'(total_t)) >> FRAC_BITS;
            n = vv / a + ((a * back * back) >> (2 * FRAC_BITS + 1));
         end
         w = (p > n) ? clamp_to(p - n, WB'(length)) : '0;
         pos64 = (goal >= origin) ? 64'(origin) + $signed(64'(w)) :
                                    64'(origin) - $signed(64'(w));
         t = WB'(elapsed_t) + WB'(cfg_period);
         elapsed_t = WORD_BITS'(clamp_to(t, WORD_MAX));
      end else begin
         elapsed_t = '0;
         total_t = '0;
         pos64 = 64'(goal);
      end
      out_word.position = pos64[WORD_BITS-1:0];
      out_word.moving = running;
      out_word.rejected = rej;
   endtask

   always @(posedge clock) begin
      rsp_type want, fresh;
      if (reset) begin
         cfg_accel_limit <= ACCEL_LIMIT_RESET;
         cfg_period <= PERIOD_RESET;
         cfg_min_move <= MIN_MOVE_RESET;
         running = 1'b0;
         origin = '0;
         goal = '0;
         speed = '0;
         accel = '0;
         length = '0;
         ramp_t = '0;
         total_t = '0;
         elapsed_t = '0;
         expected_positions.delete();
         mismatches <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL_LIMIT:   cfg_accel_limit <= csr_data[WORD_BITS-2:0];
               CSR_SAMPLE_PERIOD: cfg_period <= csr_data[PERIOD_BITS-1:0];
               CSR_MIN_MOVE:      cfg_min_move <= csr_data[MINMOVE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            step_profile(req_data, fresh);
            expected_positions.push_back(fresh);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected word: pos %0d moving %0b rejected %0b",
                           rsp_data.position, rsp_data.moving, rsp_data.rejected);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_positions.pop_front();
               if (want.position !== rsp_data.position || want.moving !== rsp_data.moving
                   || want.rejected !== rsp_data.rejected) begin
                  if (mismatches < 10)
                     $display("mismatch exp/got: pos %0d/%0d moving %0b/%0b rej %0b/%0b",
                              want.position, rsp_data.position, want.moving, rsp_data.moving,
                              want.rejected, rsp_data.rejected);
                  mismatches <= mismatches + 1;
               end
            end
         end
         pending <= expected_positions.size();
      end
   end
endmodule
`default_nettype wire

// ----- tb/trapezoid_position_profile_tb.sv -----
`default_nettype none
module trapezoid_position_profile_tb;
   import tpp_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic clock, reset;
   logic req_valid, req_stall;
   req_type req_data;
   logic rsp_valid, rsp_stall;
   rsp_type rsp_data;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [WORD_BITS-1:0] csr_data;
   int mismatches, pending;
   int cycles;
   bit gaps_on, hold_rsp;

   trapezoid_position_profile u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   trapezoid_position_profile_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // result side: random stall bursts, plus occasional long hold-offs
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else if (gaps_on && !reset && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [WORD_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle;
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic release_req;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type move_word(input int s, input int g,
                                         input logic [30:0] v, input logic [30:0] a);
      req_type r;
      r.start_req = 1'b1;
      r.start_position = s;
      r.target_position = g;
      r.cruise_speed = v;
      r.acceleration = a;
      return r;
   endfunction

   function automatic req_type tick_word();
      req_type r;
      r.start_req = 1'b0;
      r.start_position = $urandom();
      r.target_position = $urandom();
      r.cruise_speed = 31'($urandom());
      r.acceleration = 31'($urandom());
      return r;
   endfunction

   function automatic req_type random_word();
      req_type r;
      int s, len, kind;
      r = tick_word();
      if ($urandom_range(0, 29) != 0) return r;
      kind = $urandom_range(0, 9);
      s = int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      case (kind)
         0: r = move_word($urandom(), $urandom(), 31'($urandom()), 31'($urandom()));
         1: r = move_word(s, s + 50000, 31'($urandom_range(0, 6)),
                          31'($urandom_range(0, 1 << 20)));
         2: r = move_word(s, s + 50000, 31'($urandom_range(7, 1 << 20)),
                          31'($urandom_range(0, 6)));
         3: r = move_word(s, s - int'($urandom_range(0, 80)),
                          31'($urandom_range(7, 1 << 18)), 31'($urandom_range(7, 1 << 18)));
         default: begin
            len = $urandom_range(100, 1 << 20);
            r = move_word(s, $urandom_range(0, 1) ? s + len : s - len,
                          31'($urandom_range(1 << 14, 1 << 19)),
                          31'($urandom_range(1 << 14, 1 << 21)));
         end
      endcase
      return r;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (gaps_on && i == count / 2 && $urandom_range(0, 2) == 0) hold_rsp = 1'b1;
         send_word(random_word());
      end
      release_req();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      gaps_on = 1'b1;
      hold_rsp = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default registers
      send_word(tick_word());
      send_word(move_word(0, 32'sh0002_0000, 31'h0001_0000, 31'h0002_0000));
      repeat (6) send_word(tick_word());
      send_word(move_word(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff));
      repeat (3) send_word(tick_word());
      send_word(move_word(32'sh7fff_ffff, 32'sh8000_0000, 31'd7, 31'd7));
      send_word(tick_word());
      send_word(move_word(1000, 9000, 31'd6, 31'd100000));
      send_word(move_word(1000, 9000, 31'd100000, 31'd0));
      send_word(move_word(500, 566, 31'd100000, 31'd100000));
      send_word(move_word(500, 434, 31'd100000, 31'd100000));
      send_word(move_word(0, 1000, 31'h0010_0000, 31'h0010_0000));
      repeat (2) send_word(tick_word());
      send_word(move_word(0, -32'sd300000, 31'h0001_0000, 31'h0004_0000));
      send_word(tick_word());
      release_req();
      settle();

      // extremes, with the accel limit below threshold
      write_reg(CSR_ACCEL_LIMIT, 32'd1);
      write_reg(CSR_SAMPLE_PERIOD, 32'd65535);
      write_reg(CSR_MIN_MOVE, 32'd0);
      send_word(move_word(0, 1, 31'd7, 31'd7));
      send_word(move_word(0, 32'sh4000_0000, 31'h7fff_ffff, 31'h7fff_ffff));
      run_random(230);
      settle();

      write_reg(CSR_ACCEL_LIMIT, 32'h7fff_ffff);
      write_reg(CSR_SAMPLE_PERIOD, 32'd1);
      write_reg(CSR_MIN_MOVE, 32'd65535);
      hold_rsp = 1'b1;
      run_random(230);
      settle();

      write_reg(CSR_ACCEL_LIMIT, 32'($urandom_range(1 << 16, 1 << 22)));
      write_reg(CSR_SAMPLE_PERIOD, 32'($urandom_range(2000, 20000)));
      write_reg(CSR_MIN_MOVE, 32'($urandom_range(0, 200)));
      run_random(260);
      settle();

      write_reg(CSR_SAMPLE_PERIOD, 32'($urandom_range(655, 8000)));
      run_random(260);
      settle();

      // final stretch without idling
      gaps_on = 1'b0;
      write_reg(CSR_ACCEL_LIMIT, 32'd655360);
      write_reg(CSR_SAMPLE_PERIOD, 32'd4000);
      write_reg(CSR_MIN_MOVE, 32'd66);
      run_random(260);

      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- trapezoid_position_profile.f -----
rtl/tpp_pkg.sv
rtl/tpp_alu.sv
rtl/trapezoid_position_profile.sv
tb/trapezoid_position_profile_checker.sv
tb/trapezoid_position_profile_tb.sv
